### src/ialu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ialu_pkg
// Shared types and codes for the integer ALU.
// ----------------------------------------------------------------------------
package ialu_pkg;

   typedef enum logic [3:0] {
      OP_ADD = 4'd0,
      OP_SUB = 4'd1,
      OP_MUL = 4'd2,
      OP_DIV = 4'd3,
      OP_POW = 4'd4,
      OP_SHL = 4'd5,
      OP_SHR = 4'd6,
      OP_ROL = 4'd7,
      OP_ROR = 4'd8,
      OP_AND = 4'd9,
      OP_OR  = 4'd10,
      OP_XOR = 4'd11,
      OP_NEG = 4'd12
   } op_type;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_OVF  = 2'd1;
   localparam logic [1:0] ST_DIV0 = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_ITER,
      S_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;      // capture operands
      logic exec;      // non-iterative operations, or set up the iterative ones
      logic step;      // one iteration of divide / multiply / power
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic iterative; // operation needs iterations
      logic last;      // final iteration is under way
   } sts_type;

endpackage
`default_nettype wire

### src/ialu_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ialu_datapath
// Operand registers, non-iterative logic, radix-2 divider and a shift-add
// multiplier that serves both multiply and the square-and-multiply power.
// ----------------------------------------------------------------------------
module ialu_datapath #(
   parameter int DATA_WIDTH = 64
) (
   input  wire                    clock,
   input  wire ialu_pkg::cmd_type cmd,
   output ialu_pkg::sts_type      sts,
   input  wire  [3:0]             mode,
   input  wire  [63:0]            operand_a,
   input  wire  [63:0]            operand_b,
   output logic [63:0]            result,
   output logic [1:0]             status
);

   localparam int CW = $clog2(DATA_WIDTH + 1);
   localparam logic [CW-1:0] CNT_LAST = CW'(DATA_WIDTH - 1);
   localparam int SW = $clog2(DATA_WIDTH);

   typedef logic [DATA_WIDTH-1:0] word_type;

   // multiply phase: plain multiply, or for power square base or fold base into result
   typedef enum logic [1:0] {
      PH_MUL,
      PH_SQR,
      PH_ACC
   } phase_type;

   logic [3:0]      mode_ff;
   word_type        a_ff, b_ff;
   logic [63:0]     braw_ff;
   logic [63:0]     result_ff, result_in;
   logic [1:0]      status_ff, status_in;

   // divider
   word_type        quo_ff, quo_in, rem_ff, rem_in;
   // multiplier: mcand * mplier, accumulated in prod (low) with overflow flag
   word_type        mcand_ff, mcand_in, mplier_ff, mplier_in, prod_ff, prod_in;
   logic            movf_ff, movf_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   // power
   word_type        base_ff, base_in, exp_ff, exp_in, acc_ff, acc_in;
   phase_type       ph_ff, ph_in;
   logic            pdone;

   word_type        a_w, b_w, sum, diff, rol_w, ror_w, shl_w, shr_w;
   logic            carry;
   logic [SW-1:0]   rcnt;
   logic [DATA_WIDTH:0] rtrial;
   logic [DATA_WIDTH:0] padd;
   logic            mbit;
   logic            mul_end;
   logic            is_iter;
   logic            is_last;

   assign a_w = DATA_WIDTH'(operand_a);
   assign b_w = DATA_WIDTH'(operand_b);

   assign {carry, sum} = {1'b0, a_ff} + {1'b0, b_ff};
   assign diff  = a_ff - b_ff;
   assign rcnt  = SW'(braw_ff % DATA_WIDTH);
   assign shl_w = (braw_ff >= 64'(DATA_WIDTH)) ? '0 : a_ff << braw_ff[SW-1:0];
   assign shr_w = (braw_ff >= 64'(DATA_WIDTH)) ? '0 : a_ff >> braw_ff[SW-1:0];
   assign rol_w = (rcnt == '0) ? a_ff
                : (a_ff << rcnt) | (a_ff >> (SW+1)'(DATA_WIDTH - int'(rcnt)));
   assign ror_w = (rcnt == '0) ? a_ff
                : (a_ff >> rcnt) | (a_ff << (SW+1)'(DATA_WIDTH - int'(rcnt)));

   assign rtrial  = {rem_ff, quo_ff[DATA_WIDTH-1]} - {1'b0, b_ff};
   assign mbit    = mplier_ff[DATA_WIDTH-1];
   // left-to-right shift-add: prod = 2*prod + (bit ? mcand : 0)
   assign padd    = {prod_ff, 1'b0} + {1'b0, (mbit ? mcand_ff : '0)};
   assign mul_end = (cnt_ff == CNT_LAST);
   assign pdone   = (exp_ff == '0);

   // status depends on registers only, so the controller sees no loop
   assign is_iter = (mode_ff == ialu_pkg::OP_MUL) || (mode_ff == ialu_pkg::OP_POW)
                 || ((mode_ff == ialu_pkg::OP_DIV) && (b_ff != '0));
   assign is_last = (mode_ff == ialu_pkg::OP_DIV) ? mul_end
                  : (mode_ff == ialu_pkg::OP_POW) ? pdone
                  : (mul_end && (ph_ff == PH_MUL));
   assign sts = '{iterative: is_iter, last: is_last};

   always_comb begin
      result_in = result_ff;
      status_in = status_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      prod_in   = prod_ff;
      movf_in   = movf_ff;
      cnt_in    = cnt_ff;
      base_in   = base_ff;
      exp_in    = exp_ff;
      acc_in    = acc_ff;
      ph_in     = ph_ff;
      if (cmd.exec) begin
         status_in = ialu_pkg::ST_OK;
         cnt_in    = '0;
         unique case (mode_ff)
            ialu_pkg::OP_ADD: begin
               result_in = 64'(sum);
               if (carry) status_in = ialu_pkg::ST_OVF;
            end
            ialu_pkg::OP_SUB: result_in = 64'(diff);
            ialu_pkg::OP_MUL: begin
               mcand_in = a_ff; mplier_in = b_ff; prod_in = '0; movf_in = 1'b0;
               ph_in = PH_MUL;
            end
            ialu_pkg::OP_DIV: begin
               result_in = '0;
               if (b_ff == '0) status_in = ialu_pkg::ST_DIV0;
               quo_in = a_ff; rem_in = '0;
            end
            ialu_pkg::OP_POW: begin
               base_in = a_ff; exp_in = b_ff; acc_in = word_type'(1);
               // first fold the low exponent bit, if any
               mcand_in = word_type'(1); mplier_in = a_ff; prod_in = '0;
               ph_in = PH_ACC;
            end
            ialu_pkg::OP_SHL: result_in = 64'(shl_w);
            ialu_pkg::OP_SHR: result_in = 64'(shr_w);
            ialu_pkg::OP_ROL: result_in = 64'(rol_w);
            ialu_pkg::OP_ROR: result_in = 64'(ror_w);
            ialu_pkg::OP_AND: result_in = 64'(a_ff & b_ff);
            ialu_pkg::OP_OR:  result_in = 64'(a_ff | b_ff);
            ialu_pkg::OP_XOR: result_in = 64'(a_ff ^ b_ff);
            ialu_pkg::OP_NEG: result_in = 64'(word_type'(0) - a_ff);
            default:          result_in = '0;
         endcase
      end else if (cmd.step) begin
         if (mode_ff == ialu_pkg::OP_DIV) begin
            cnt_in = cnt_ff + 1'b1;
            if (!rtrial[DATA_WIDTH]) begin
               rem_in = rtrial[DATA_WIDTH-1:0];
               quo_in = {quo_ff[DATA_WIDTH-2:0], 1'b1};
            end else begin
               rem_in = {rem_ff[DATA_WIDTH-2:0], quo_ff[DATA_WIDTH-1]};
               quo_in = {quo_ff[DATA_WIDTH-2:0], 1'b0};
            end
            if (mul_end) begin
               result_in = 64'(quo_in);
            end
         end else if (mode_ff == ialu_pkg::OP_POW && pdone) begin
            result_in = 64'(acc_ff);
         end else begin
            // one multiplier bit
            cnt_in    = cnt_ff + 1'b1;
            prod_in   = padd[DATA_WIDTH-1:0];
            movf_in   = movf_ff | padd[DATA_WIDTH] | prod_ff[DATA_WIDTH-1];
            mplier_in = mplier_ff << 1;
            if (mul_end) begin
               cnt_in = '0;
               unique case (ph_ff)
                  PH_MUL: begin
                     result_in = 64'(prod_in);
                     status_in = movf_in ? ialu_pkg::ST_OVF : ialu_pkg::ST_OK;
                  end
                  PH_ACC: begin
                     if (exp_ff[0]) acc_in = prod_in;
                     mcand_in  = base_ff; mplier_in = base_ff; prod_in = '0;
                     ph_in     = PH_SQR;
                  end
                  PH_SQR: begin
                     base_in   = prod_in;
                     exp_in    = exp_ff >> 1;
                     mcand_in  = acc_ff; mplier_in = prod_in; prod_in = '0;
                     ph_in     = PH_ACC;
                  end
                  default: ph_in = PH_MUL;
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= mode;
         a_ff    <= a_w;
         b_ff    <= b_w;
         braw_ff <= operand_b;
      end
      result_ff <= result_in;
      status_ff <= status_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      prod_ff   <= prod_in;
      movf_ff   <= movf_in;
      cnt_ff    <= cnt_in;
      base_ff   <= base_in;
      exp_ff    <= exp_in;
      acc_ff    <= acc_in;
      ph_ff     <= ph_in;
   end

   assign result = result_ff;
   assign status = status_ff;

endmodule
`default_nettype wire

### src/ialu_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ialu_ctrl
// Sequencer: accept a word, run it through the datapath, hold the result.
// ----------------------------------------------------------------------------
module ialu_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output ialu_pkg::cmd_type      cmd,
   input  wire ialu_pkg::sts_type sts
);

   ialu_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ialu_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ialu_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ialu_pkg::S_EXEC;
            end
         end
         ialu_pkg::S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = sts.iterative ? ialu_pkg::S_ITER : ialu_pkg::S_DONE;
         end
         ialu_pkg::S_ITER: begin
            cmd.step = 1'b1;
            if (sts.last) state_in = ialu_pkg::S_DONE;
         end
         ialu_pkg::S_DONE: begin
            rsp_valid = 1'b1;
            // take the next word as this one leaves
            req_ready = rsp_ready;
            if (rsp_ready) begin
               if (req_valid) begin
                  cmd.load = 1'b1;
                  state_in = ialu_pkg::S_EXEC;
               end else begin
                  state_in = ialu_pkg::S_IDLE;
               end
            end
         end
         default: state_in = ialu_pkg::S_IDLE;
      endcase
   end

endmodule
`default_nettype wire

### src/integer_alu_with_error_flags.sv
`default_nettype none
// ----------------------------------------------------------------------------
// integer_alu_with_error_flags
// Unsigned integer ALU with overflow and divide-by-zero status.
// ----------------------------------------------------------------------------
// One word at a time. Add, sub, shifts, rotates, logic ops and negate pass
// from accept through the execute state to the done state. Divide runs
// one quotient bit per cycle in a restoring divider; multiply runs one
// multiplier bit per cycle in a shift-add unit. Power runs two such
// multiplies per exponent bit up to the highest set bit. A new word is
// taken in the cycle its predecessor's result is taken.
module integer_alu_with_error_flags #(
   parameter int DATA_WIDTH = 64
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [3:0]  req_mode,
   input  wire  [63:0] req_operand_a,
   input  wire  [63:0] req_operand_b,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [63:0] rsp_result,
   output logic [1:0]  rsp_status
);

   ialu_pkg::cmd_type cmd;
   ialu_pkg::sts_type sts;

   ialu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   ialu_datapath #(.DATA_WIDTH(DATA_WIDTH)) u_dp (
      .clock     (clock),
      .cmd       (cmd),
      .sts       (sts),
      .mode      (req_mode),
      .operand_a (req_operand_a),
      .operand_b (req_operand_b),
      .result    (rsp_result),
      .status    (rsp_status)
   );

endmodule
`default_nettype wire
